### design/bup_pkg.sv
// ----------------------------------------------------------------------------
// bup_pkg
// Types and constants shared by the bilinear undistortion pixel block and
// its channel interfaces.
// ----------------------------------------------------------------------------
package bup_pkg;

  // field widths
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned PixelWidth = 8;
  localparam int unsigned InterpWeight = 8;
  localparam int unsigned PixelWeight = 8;
  localparam int unsigned SobelShift = 3;

  // pixel centring and output bias
  localparam logic [PixelWidth-1:0] CentreLevel = 8'h7F;
  localparam logic [PixelWidth-1:0] TopBitFlip = 8'h80;

  // configuration register map, index = paddr[3:2]
  localparam int unsigned AddrWidth = 4;
  localparam logic [1:0] RegXOffset = 2'd0;
  localparam logic [1:0] RegYOffset = 2'd1;
  localparam logic [1:0] RegResultShift = 2'd2;

  // input request: one map entry and its four neighbours
  typedef struct packed {
    logic [CoordWidth-1:0] coord_x;
    logic [CoordWidth-1:0] coord_y;
    logic [PixelWidth-1:0] pixel_low_left;
    logic [PixelWidth-1:0] pixel_low_right;
    logic [PixelWidth-1:0] pixel_high_left;
    logic [PixelWidth-1:0] pixel_high_right;
  } in_item_t;

  // output request: interpolated pixel and its source position
  typedef struct packed {
    logic [PixelWidth-1:0] pixel_out;
    logic [CoordWidth-1:0] source_col;
    logic [CoordWidth-1:0] source_row;
  } out_item_t;

endpackage

### design/bup_in_if.sv
// ----------------------------------------------------------------------------
// bup_in_if
// Valid/ready channel carrying one map entry with its four source pixels.
// ----------------------------------------------------------------------------
interface bup_in_if;
  logic              valid;
  logic              ready;
  bup_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/bup_out_if.sv
// ----------------------------------------------------------------------------
// bup_out_if
// Valid/ready channel carrying one interpolated pixel and its source position.
// ----------------------------------------------------------------------------
interface bup_out_if;
  logic               valid;
  logic               ready;
  bup_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/bilinear_undistort_pixel.sv
// ----------------------------------------------------------------------------
// bilinear_undistort_pixel
// Fixed-point bilinear interpolation of one undistorted pixel per request.
// ----------------------------------------------------------------------------
//   channel   dir   handshake        payload
//   req_i     in    valid / ready    coord_x, coord_y, four corner pixels
//   res_o     out   valid / ready    pixel_out, source_col, source_row
//   apb       in    psel / penable   x_offset, y_offset, result_shift
//
// One request per clock while res_o is not stalled; the accepting edge loads
// stage 1, and res_o.valid rises once the request has passed stages 2, 3 and 4.
// The four stages are: weights and centring, corner products, sum, shift and
// saturate into the output register.
// rst_ni is asynchronous, active low; it clears all stage valid bits and the
// configuration registers.
// Each stage loads when it is empty or its successor loads, so bubbles close
// up under a stall and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bilinear_undistort_pixel #(
  parameter int unsigned FRACTION_BITS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bup_in_if.sink                         req_i,
  bup_out_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bup_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned ProdWidth = 2 * FRACTION_BITS;
  localparam int unsigned WeightShift = 2 * FRACTION_BITS - bup_pkg::InterpWeight;
  localparam int unsigned WeightWidth = bup_pkg::InterpWeight;
  localparam int unsigned CentWidth = bup_pkg::PixelWeight + 1;
  localparam int unsigned TermWidth = WeightWidth + 1 + CentWidth;
  localparam int unsigned SumWidth = TermWidth + 2;
  localparam int unsigned CW = bup_pkg::CoordWidth;

  // configuration registers
  logic [CW-1:0] x_offset_q;
  logic [CW-1:0] y_offset_q;
  logic [1:0]    result_shift_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q     <= '0;
      y_offset_q     <= '0;
      result_shift_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bup_pkg::RegXOffset:     x_offset_q     <= pwdata[CW-1:0];
        bup_pkg::RegYOffset:     y_offset_q     <= pwdata[CW-1:0];
        bup_pkg::RegResultShift: result_shift_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (paddr[3:2])
      bup_pkg::RegXOffset:     prdata = {16'd0, x_offset_q};
      bup_pkg::RegYOffset:     prdata = {16'd0, y_offset_q};
      bup_pkg::RegResultShift: prdata = {30'd0, result_shift_q};
      default:                 prdata = '0;
    endcase
  end

  // stage valids and load enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic ld1, ld2, ld3, ld4;

  assign ld4 = !v4_q || res_o.ready;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign req_i.ready = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= req_i.valid;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  // stage 1: axis weights, corner weights, centred pixels, source position
  logic [FRACTION_BITS-1:0]         xh, xl, yh, yl;
  logic [ProdWidth-1:0]             prod_d [4];
  logic [bup_pkg::PixelWidth-1:0]   pix_in [4];
  logic [WeightWidth-1:0]           w_q [4];
  logic signed [CentWidth-1:0]      cent_q [4];
  logic [CW-1:0]                    col1_q, row1_q;

  assign xh = req_i.data.coord_x[FRACTION_BITS-1:0];
  assign xl = ~req_i.data.coord_x[FRACTION_BITS-1:0];
  assign yh = req_i.data.coord_y[FRACTION_BITS-1:0];
  assign yl = ~req_i.data.coord_y[FRACTION_BITS-1:0];

  assign pix_in[0] = req_i.data.pixel_low_left;
  assign pix_in[1] = req_i.data.pixel_low_right;
  assign pix_in[2] = req_i.data.pixel_high_left;
  assign pix_in[3] = req_i.data.pixel_high_right;

  assign prod_d[0] = ProdWidth'(xl) * ProdWidth'(yl);
  assign prod_d[1] = ProdWidth'(xh) * ProdWidth'(yl);
  assign prod_d[2] = ProdWidth'(xl) * ProdWidth'(yh);
  assign prod_d[3] = ProdWidth'(xh) * ProdWidth'(yh);

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      for (int i = 0; i < 4; i++) begin
        w_q[i]    <= prod_d[i][ProdWidth-1:WeightShift];
        cent_q[i] <= $signed({1'b0, pix_in[i]}) - $signed({1'b0, bup_pkg::CentreLevel});
      end
      col1_q <= (req_i.data.coord_x >> FRACTION_BITS) + x_offset_q;
      row1_q <= (req_i.data.coord_y >> FRACTION_BITS) + y_offset_q;
    end
  end

  // stage 2: weighted corners, operands widened before the multiply
  logic signed [TermWidth-1:0] term_q [4];
  logic [CW-1:0]               col2_q, row2_q;

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      for (int i = 0; i < 4; i++) begin
        term_q[i] <= TermWidth'($signed({1'b0, w_q[i]})) * TermWidth'(cent_q[i]);
      end
      col2_q <= col1_q;
      row2_q <= row1_q;
    end
  end

  // stage 3: sum of the four corners
  logic signed [SumWidth-1:0] sum_q;
  logic [CW-1:0]              col3_q, row3_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      sum_q <= SumWidth'(term_q[0]) + SumWidth'(term_q[1])
             + SumWidth'(term_q[2]) + SumWidth'(term_q[3]);
      col3_q <= col2_q;
      row3_q <= row2_q;
    end
  end

  // stage 4: scale, saturate to 16 bits, bias the top byte
  logic signed [SumWidth-1:0] shifted;
  logic [15:0]                sat;
  bup_pkg::out_item_t         out_q;

  assign shifted = sum_q >>> result_shift_q;

  always_comb begin
    if (shifted > SumWidth'(32767)) begin
      sat = 16'h7FFF;
    end else if (shifted < -SumWidth'(32768)) begin
      sat = 16'h8000;
    end else begin
      sat = shifted[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      out_q.pixel_out  <= sat[15:8] ^ bup_pkg::TopBitFlip;
      out_q.source_col <= col3_q;
      out_q.source_row <= row3_q;
    end
  end

  assign res_o.valid = v4_q;
  assign res_o.data  = out_q;

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> req_i.ready)
    else $error("input stalled with empty output register");

  // an accepted request lands in the first stage
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> v1_q)
    else $error("accepted request lost at stage 1");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && res_o.ready && !v3_q) |=> !res_o.valid)
    else $error("result repeated after being taken");

endmodule

### bench/bup_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bup_scoreboard_pkg
// Pixel predictor and result store for the bilinear undistortion bench. Every
// accepted request is turned into its expected pixel and source position,
// which are matched in order against the results leaving the block.
// ----------------------------------------------------------------------------
package bup_scoreboard_pkg;
  import bup_pkg::*;

  localparam int unsigned FractionBits = 6;
  localparam int unsigned WeightShift = 2 * FractionBits - InterpWeight;
  localparam int unsigned MaxReports = 10;

  class undistort_scoreboard;
    logic [CoordWidth-1:0] x_offset;
    logic [CoordWidth-1:0] y_offset;
    logic [1:0]            result_shift;
    out_item_t             pending_results[$];
    int                    mismatches;

    function new();
      x_offset = '0;
      y_offset = '0;
      result_shift = '0;
      mismatches = 0;
    endfunction

    // mirror of a register write; bits above the register width drop out
    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegXOffset:     x_offset = value[CoordWidth-1:0];
        RegYOffset:     y_offset = value[CoordWidth-1:0];
        RegResultShift: result_shift = value[1:0];
        default: ;
      endcase
    endfunction

    // centred pixel times its corner weight
    function int corner_term(int weight, logic [PixelWidth-1:0] pixel);
      int level;
      level = pixel;
      return weight * (level - int'(CentreLevel));
    endfunction

    function out_item_t interpolate_pixel(in_item_t req);
      int        x_hi, x_lo, y_hi, y_lo;
      int        w_ll, w_lr, w_hl, w_hr;
      int        total;
      out_item_t res;
      x_hi = req.coord_x[FractionBits-1:0];
      y_hi = req.coord_y[FractionBits-1:0];
      x_lo = (2 ** FractionBits - 1) - x_hi;
      y_lo = (2 ** FractionBits - 1) - y_hi;
      w_ll = (x_lo * y_lo) >> WeightShift;
      w_lr = (x_hi * y_lo) >> WeightShift;
      w_hl = (x_lo * y_hi) >> WeightShift;
      w_hr = (x_hi * y_hi) >> WeightShift;
      total = corner_term(w_ll, req.pixel_low_left) + corner_term(w_lr, req.pixel_low_right)
            + corner_term(w_hl, req.pixel_high_left) + corner_term(w_hr, req.pixel_high_right);
      // arithmetic shift floors negative sums, then saturate to 16 bits signed
      total = total >>> result_shift;
      if (total > 32767) total = 32767;
      if (total < -32768) total = -32768;
      res.pixel_out = total[15:8] ^ TopBitFlip;
      res.source_col = (req.coord_x >> FractionBits) + x_offset;
      res.source_row = (req.coord_y >> FractionBits) + y_offset;
      return res;
    endfunction

    function void note_request(in_item_t req);
      pending_results.push_back(interpolate_pixel(req));
    endfunction

    function void check_result(out_item_t res);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: pixel %h col %h row %h",
                   res.pixel_out, res.source_col, res.source_row);
        return;
      end
      want = pending_results.pop_front();
      if (res.pixel_out !== want.pixel_out || res.source_col !== want.source_col ||
          res.source_row !== want.source_row) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("mismatch: expected pixel %h col %h row %h, got pixel %h col %h row %h",
                   want.pixel_out, want.source_col, want.source_row,
                   res.pixel_out, res.source_col, res.source_row);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the bilinear undistortion pixel block. A directed set of corner
// fractions and pixel extremes is followed by random requests over four
// register settings and four idle/stall profiles, including a long output
// hold-off. Results are checked in order against the scoreboard predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import bup_pkg::*;
  import bup_scoreboard_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int RandomPerPhase = 400;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;

  undistort_scoreboard sb = new();

  bup_in_if  req_if ();
  bup_out_if res_if ();

  bilinear_undistort_pixel #(
    .FRACTION_BITS(FractionBits)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("bilinear_undistort_pixel verification failed");
    $finish;
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      res_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check_result(res_if.data);
  end

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(in_item_t req);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      req_if.data = in_item_t'({$urandom, $urandom});
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data = req;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(req);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic [15:0] cx, logic [15:0] cy,
                                         logic [7:0] ll, logic [7:0] lr,
                                         logic [7:0] hl, logic [7:0] hr);
    in_item_t req;
    req.coord_x = cx;
    req.coord_y = cy;
    req.pixel_low_left = ll;
    req.pixel_low_right = lr;
    req.pixel_high_left = hl;
    req.pixel_high_right = hr;
    return req;
  endfunction

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return CentreLevel;
      default: return 8'($urandom);
    endcase
  endfunction

  // corner fractions and extreme pixels
  task automatic send_directed();
    logic [15:0] coords[5];
    coords = '{16'h0000, 16'hFFFF, 16'h003F, 16'hFFC0, 16'h8020};
    foreach (coords[i]) begin
      send_request(make_item(coords[i], coords[(i + 2) % 5], 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_item(coords[(i + 1) % 5], coords[i], 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_item(coords[i], coords[i], 8'h00, 8'hFF, 8'hFF, 8'h00));
      send_request(make_item(coords[(i + 3) % 5], coords[(i + 4) % 5],
                             8'hFF, 8'h00, 8'h7F, 8'h80));
    end
    stop_sending();
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      send_request(make_item(16'($urandom), 16'($urandom), random_pixel(), random_pixel(),
                             random_pixel(), random_pixel()));
    end
    stop_sending();
  endtask

  task automatic configure(logic [15:0] x_off, logic [15:0] y_off, logic [1:0] shift);
    write_register(RegXOffset, {16'($urandom), x_off});
    write_register(RegYOffset, {16'($urandom), y_off});
    write_register(RegResultShift, {30'($urandom), shift});
    write_register(RegUnused, $urandom);
  endtask

  // main sequence
  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_directed();
    wait_drained();

    // no idling, with a long output hold-off that fills the pipeline
    configure(16'h7FFF, 16'h8000, 2'd3);
    hold_request = 1'b1;
    send_random(RandomPerPhase);
    wait_drained();

    // sender idle
    send_idle_pct = 51;
    configure(16'hFFFF, 16'h0001, 2'd1);
    send_random(RandomPerPhase);
    wait_drained();

    // receiver stalling
    send_idle_pct = 0;
    recv_stall_pct = 51;
    configure(16'($urandom), 16'($urandom), 2'd2);
    send_random(RandomPerPhase);
    wait_drained();

    // both idle and stalling
    send_idle_pct = 28;
    recv_stall_pct = 28;
    configure(16'h8000, 16'h7FFF, 2'd0);
    send_random(RandomPerPhase);
    wait_drained();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bilinear_undistort_pixel verification clean");
    end else begin
      $display("bilinear_undistort_pixel verification failed");
    end
    $finish;
  end

endmodule
